### rtl/ufp_pkg.sv
`default_nettype none

package ufp_pkg;

    // Payload store geometry.
    localparam int MAX_PAYLOAD = 256;
    localparam int PAY_AW      = $clog2(MAX_PAYLOAD);
    localparam int POS_W       = $clog2(MAX_PAYLOAD + 1);

    // Configuration register indexes and reset values.
    localparam int         CFG_IDX_W       = 1;
    localparam logic [0:0] CFG_SYNC_FIRST  = 1'd0;
    localparam logic [0:0] CFG_SYNC_SECOND = 1'd1;
    localparam logic [7:0] SYNC_FIRST_RST  = 8'd181;
    localparam logic [7:0] SYNC_SECOND_RST = 8'd98;

    // Command codes.
    localparam logic [1:0] CMD_RECV    = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    // Error codes.
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_OVERRUN     = 3'd1;
    localparam logic [2:0] ERR_TOO_LONG    = 3'd2;
    localparam logic [2:0] ERR_CHECKSUM    = 3'd3;
    localparam logic [2:0] ERR_UNEXPECTED  = 3'd4;
    localparam logic [2:0] ERR_OUT_OF_SYNC = 3'd5;

    // Parser phases.
    localparam logic [3:0] PH_HUNT    = 4'd0;
    localparam logic [3:0] PH_SYNC1   = 4'd1;
    localparam logic [3:0] PH_SYNC2   = 4'd2;
    localparam logic [3:0] PH_CLASS   = 4'd3;
    localparam logic [3:0] PH_IDENT   = 4'd4;
    localparam logic [3:0] PH_LEN1    = 4'd5;
    localparam logic [3:0] PH_PAYLOAD = 4'd6;
    localparam logic [3:0] PH_CK_A    = 4'd7;
    localparam logic [3:0] PH_CK_B    = 4'd8;

    // Result of one transaction, without the payload read data.
    typedef struct packed {
        logic       frame_ready;
        logic       frame_event;
        logic       error_event;
        logic [2:0] last_error;
        logic [15:0] error_total;
        logic [7:0] frame_class;
        logic [7:0] frame_ident;
        logic [8:0] payload_length;
        logic       is_read;
        logic [3:0] parser_phase;
    } t_result;

endpackage

`default_nettype wire

### rtl/ufp_ram.sv
`default_nettype none

module ufp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Single write port, registered read port that holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/ufp_parser.sv
`default_nettype none

module ufp_parser (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic [1:0]            i_command,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic [7:0]            i_read_index,
    input  wire logic [7:0]            i_sync_first,
    input  wire logic [7:0]            i_sync_second,
    output logic                       o_wr_en,
    output logic [ufp_pkg::PAY_AW-1:0] o_wr_addr,
    output logic [7:0]                 o_wr_data,
    output logic                       o_rd_en,
    output logic [ufp_pkg::PAY_AW-1:0] o_rd_addr,
    output ufp_pkg::t_result           o_result
);

    import ufp_pkg::*;

    logic [3:0]       r_phase, n_phase;
    logic [7:0]       r_sum_a, n_sum_a;
    logic [7:0]       r_sum_b, n_sum_b;
    logic [7:0]       r_class, n_class;
    logic [7:0]       r_ident, n_ident;
    logic [15:0]      r_length, n_length;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_ready, n_ready;
    logic [15:0]      r_err_count, n_err_count;
    logic [2:0]       r_err_code, n_err_code;

    logic             frame_ev;
    logic             error_ev;
    logic             read_ok;
    logic [POS_W-1:0] pos_inc;
    logic [15:0]      len_full;

    // Per-byte deframing step, release and payload read on the accepted transaction.
    always_comb begin
        n_phase     = r_phase;
        n_sum_a     = r_sum_a;
        n_sum_b     = r_sum_b;
        n_class     = r_class;
        n_ident     = r_ident;
        n_length    = r_length;
        n_pos       = r_pos;
        n_ready     = r_ready;
        n_err_count = r_err_count;
        n_err_code  = r_err_code;
        frame_ev    = 1'b0;
        error_ev    = 1'b0;
        read_ok     = 1'b0;
        o_wr_en     = 1'b0;
        pos_inc     = r_pos + 1'b1;
        len_full    = {i_data_byte, r_length[7:0]};

        if (i_accept) begin
            case (i_command)
                CMD_RECV: begin
                    if (r_phase < PH_CK_A) begin
                        n_sum_a = r_sum_a + i_data_byte;
                        n_sum_b = r_sum_b + n_sum_a;
                    end
                    case (r_phase)
                        PH_HUNT: begin
                            if (i_data_byte == i_sync_first) begin
                                n_phase = PH_SYNC1;
                            end
                        end
                        PH_SYNC1: begin
                            if (i_data_byte != i_sync_second) begin
                                error_ev   = 1'b1;
                                n_err_code = ERR_OUT_OF_SYNC;
                            end else begin
                                n_sum_a = '0;
                                n_sum_b = '0;
                                n_phase = PH_SYNC2;
                            end
                        end
                        PH_SYNC2: begin
                            if (r_ready) begin
                                error_ev   = 1'b1;
                                n_err_code = ERR_OVERRUN;
                            end else begin
                                n_class = i_data_byte;
                                n_phase = PH_CLASS;
                            end
                        end
                        PH_CLASS: begin
                            n_ident = i_data_byte;
                            n_phase = PH_IDENT;
                        end
                        PH_IDENT: begin
                            n_length = {8'd0, i_data_byte};
                            n_phase  = PH_LEN1;
                        end
                        PH_LEN1: begin
                            n_length = len_full;
                            if (32'(len_full) > MAX_PAYLOAD) begin
                                error_ev   = 1'b1;
                                n_err_code = ERR_TOO_LONG;
                            end else begin
                                n_pos   = '0;
                                n_phase = (len_full == 16'd0) ? PH_CK_A : PH_PAYLOAD;
                            end
                        end
                        PH_PAYLOAD: begin
                            o_wr_en = (32'(r_pos) < MAX_PAYLOAD);
                            n_pos   = pos_inc;
                            if (16'(pos_inc) >= r_length) begin
                                n_phase = PH_CK_A;
                            end
                        end
                        PH_CK_A: begin
                            if (i_data_byte != r_sum_a) begin
                                error_ev   = 1'b1;
                                n_err_code = ERR_CHECKSUM;
                            end else begin
                                n_phase = PH_CK_B;
                            end
                        end
                        PH_CK_B: begin
                            if (i_data_byte != r_sum_b) begin
                                error_ev   = 1'b1;
                                n_err_code = ERR_CHECKSUM;
                            end else begin
                                n_ready  = 1'b1;
                                n_phase  = PH_HUNT;
                                frame_ev = 1'b1;
                            end
                        end
                        default: begin
                            error_ev   = 1'b1;
                            n_err_code = ERR_UNEXPECTED;
                        end
                    endcase
                    // Every framing error resyncs and bumps the counter.
                    if (error_ev) begin
                        n_err_count = r_err_count + 16'd1;
                        n_phase     = PH_HUNT;
                    end
                end
                CMD_RELEASE: begin
                    n_ready = 1'b0;
                end
                CMD_READ: begin
                    read_ok = (32'(i_read_index) < MAX_PAYLOAD);
                end
                default: begin
                end
            endcase
        end
    end

    // Payload store access.
    assign o_wr_addr = r_pos[PAY_AW-1:0];
    assign o_wr_data = i_data_byte;
    assign o_rd_en   = read_ok;
    assign o_rd_addr = PAY_AW'(i_read_index);

    // Result fields reflect the state after this transaction.
    always_comb begin
        o_result.frame_ready    = n_ready;
        o_result.frame_event    = frame_ev;
        o_result.error_event    = error_ev;
        o_result.last_error     = n_err_code;
        o_result.error_total    = n_err_count;
        o_result.frame_class    = n_class;
        o_result.frame_ident    = n_ident;
        o_result.payload_length = (|n_length[15:9]) ? 9'd511 : n_length[8:0];
        o_result.is_read        = read_ok;
        o_result.parser_phase   = n_phase;
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_sum_a     <= '0;
            r_sum_b     <= '0;
            r_class     <= '0;
            r_ident     <= '0;
            r_length    <= '0;
            r_pos       <= '0;
            r_ready     <= 1'b0;
            r_err_count <= '0;
            r_err_code  <= ERR_NONE;
        end else begin
            r_phase     <= n_phase;
            r_sum_a     <= n_sum_a;
            r_sum_b     <= n_sum_b;
            r_class     <= n_class;
            r_ident     <= n_ident;
            r_length    <= n_length;
            r_pos       <= n_pos;
            r_ready     <= n_ready;
            r_err_count <= n_err_count;
            r_err_code  <= n_err_code;
        end
    end

`ifndef SYNTHESIS
    // A reported error advances the error counter by exactly one.
    a_err_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && error_ev) |=> (r_err_count == $past(r_err_count) + 16'd1))
        else $error("error counter did not advance on a framing error");

    // A completed frame leaves the ready flag set and the parser hunting.
    a_frame_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && frame_ev) |=> (r_ready && r_phase == PH_HUNT))
        else $error("completed frame did not set the ready flag");

    // While payload is collected the position stays below the length.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (16'(r_pos) < r_length))
        else $error("payload position passed the frame length");
`endif

endmodule

`default_nettype wire

### rtl/ufp_outq.sv
`default_nettype none

module ufp_outq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire ufp_pkg::t_result i_result,
    input  wire logic [7:0]       i_rd_data,
    input  wire logic             i_out_stall,
    output logic                  o_full,
    output logic                  o_out_valid,
    output ufp_pkg::t_result      o_result,
    output logic [7:0]            o_read_data
);

    import ufp_pkg::*;

    logic    r_s1_valid;
    t_result r_s1_res;
    logic    r_out_valid;
    t_result r_out_res;
    logic [7:0] r_out_rdata;
    logic    s1_move;

    // The first stage drains whenever the output register is free or being taken.
    assign s1_move = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_full  = r_s1_valid && !s1_move;

    // Control: stage and output valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_push) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: memory read data joins its result when it leaves the first stage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_s1_res <= i_result;
        end
        if (s1_move) begin
            r_out_res   <= r_s1_res;
            r_out_rdata <= r_s1_res.is_read ? i_rd_data : 8'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out_res;
    assign o_read_data = r_out_rdata;

`ifndef SYNTHESIS
    // A held first stage with a free output register always moves on.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_out_valid) |=> r_out_valid)
        else $error("first stage did not drain into a free output register");

    // New transactions are refused only while both stages are full.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input refused with a free stage");

    // A stalled result stays on the outputs unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=>
            (r_out_valid && $stable(r_out_res) && $stable(r_out_rdata)))
        else $error("stalled result changed on the outputs");
`endif

endmodule

`default_nettype wire

### rtl/ubx_frame_parser_top.sv
// UBX frame deframer with Fletcher-8 checking.
// Input channel (i_in_valid / o_in_stall): one transaction carries a command,
// a data byte and a read index. Command receive feeds one serial byte to the
// parser, release clears the held-frame flag, read fetches a stored payload
// byte. The payload sits in a 256-byte synchronous RAM.
// Output channel (o_out_valid / i_out_stall): one result per input
// transaction, in order, with flags, error code and counter, frame header
// fields, the payload length, the read byte and the parser phase.
// A result is registered in the first stage of the output queue, then in its
// output register. Throughput is one transaction per cycle while the receiver
// does not stall; the scalar state updates in the accept cycle, and the RAM
// read data is registered and joins its result as it leaves the first stage.
// When the receiver stalls, results fill a two-entry output queue; the input
// stalls only once both entries are full.
// Configuration (i_cfg_valid / o_cfg_ready) sets the two sync bytes and is
// always ready; write it only while the block is idle.
// Synchronous reset clears the parser to hunting, the counters to zero and
// the sync bytes to their defaults; the payload RAM is not cleared.
`default_nettype none

module ubx_frame_parser_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [ufp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_command,
    input  wire logic [7:0]                    i_data_byte,
    input  wire logic [7:0]                    i_read_index,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_frame_ready,
    output logic                               o_frame_event,
    output logic                               o_error_event,
    output logic [2:0]                         o_last_error,
    output logic [15:0]                        o_error_total,
    output logic [7:0]                         o_frame_class,
    output logic [7:0]                         o_frame_ident,
    output logic [8:0]                         o_payload_length,
    output logic [7:0]                         o_read_data,
    output logic [3:0]                         o_parser_phase
);

    import ufp_pkg::*;

    logic [7:0]        r_sync_first;
    logic [7:0]        r_sync_second;
    logic              accept;
    logic              full;
    logic              wr_en;
    logic [PAY_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [PAY_AW-1:0] rd_addr;
    logic [7:0]        rd_data;
    t_result           step_res;
    t_result           out_res;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input handshake.
    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    ufp_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_command     (i_command),
        .i_data_byte   (i_data_byte),
        .i_read_index  (i_read_index),
        .i_sync_first  (r_sync_first),
        .i_sync_second (r_sync_second),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .o_result      (step_res)
    );

    ufp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    ufp_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_result    (step_res),
        .i_rd_data   (rd_data),
        .i_out_stall (i_out_stall),
        .o_full      (full),
        .o_out_valid (o_out_valid),
        .o_result    (out_res),
        .o_read_data (o_read_data)
    );

    // Result fields.
    assign o_frame_ready    = out_res.frame_ready;
    assign o_frame_event    = out_res.frame_event;
    assign o_error_event    = out_res.error_event;
    assign o_last_error     = out_res.last_error;
    assign o_error_total    = out_res.error_total;
    assign o_frame_class    = out_res.frame_class;
    assign o_frame_ident    = out_res.frame_ident;
    assign o_payload_length = out_res.payload_length;
    assign o_parser_phase   = out_res.parser_phase;

endmodule

`default_nettype wire
